>>> hw/rtl/jbt_pkg.sv
// Shared types, character codes and result layout for the JSON byte tokenizer.
package jbt_pkg;

  localparam int INT_BITS        = 32;
  localparam int FRAC_BITS       = 30;
  localparam int FCNT_BITS       = 4;
  localparam logic [FCNT_BITS-1:0] FRAC_DIGITS_MAX = 4'd9;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COLON    = 4'd4,
    KIND_STRCHAR  = 4'd5,
    KIND_STREND   = 4'd6,
    KIND_NUMBER   = 4'd7,
    KIND_END      = 4'd8,
    KIND_ERROR    = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_INT  = 2'd2,
    MODE_FRAC = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNEXPECTED   = 2'd1,
    ERR_UNTERMINATED = 2'd2
  } err_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            char_value;
    logic                  is_negative;
    logic [INT_BITS-1:0]   int_part;
    logic [FRAC_BITS-1:0]  frac_part;
    logic [FCNT_BITS-1:0]  frac_count;
    err_t                  error_code;
    logic                  error_seen;
    logic                  last_of_run;
  } rslt_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  sign;
    logic [INT_BITS-1:0]   int_acc;
    logic [FRAC_BITS-1:0]  frac_acc;
    logic [FCNT_BITS-1:0]  frac_cnt;
    logic                  sticky;
  } scan_state_t;

endpackage

>>> hw/rtl/jbt_scan.sv
// Combinational scan step: one byte plus scanner state gives up to two results.
module jbt_scan
  import jbt_pkg::*;
(
  input  scan_state_t st,
  input  logic [7:0]  text_byte,
  output scan_state_t st_nxt,
  output logic [1:0]  res_cnt,
  output rslt_t       res0,
  output rslt_t       res1
);

  logic                 is_digit;
  logic                 is_space;
  logic [7:0]           dsub;
  logic [3:0]           digit;
  logic [INT_BITS+3:0]  int_wide;
  logic [FRAC_BITS+3:0] frac_wide;
  logic                 idle_go;
  logic                 idle_emit;
  rslt_t                idle_res;
  rslt_t                zero_res;

  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_space = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign dsub     = text_byte - CH_ZERO;
  assign digit    = dsub[3:0];

  // acc*10 + d, computed wide so the saturation test is a plain overflow check
  assign int_wide  = ({4'b0, st.int_acc} << 3) + ({4'b0, st.int_acc} << 1)
                   + {{INT_BITS{1'b0}}, digit};
  assign frac_wide = ({4'b0, st.frac_acc} << 3) + ({4'b0, st.frac_acc} << 1)
                   + {{FRAC_BITS{1'b0}}, digit};

  always_comb begin
    zero_res   = '0;
    st_nxt     = st;
    res_cnt    = 2'd0;
    res0       = '0;
    res1       = '0;
    idle_go    = 1'b0;
    idle_emit  = 1'b0;
    idle_res   = '0;

    unique case (st.mode)
      MODE_STR: begin
        if (text_byte == CH_QUOTE) begin
          res0            = zero_res;
          res0.kind       = KIND_STREND;
          res0.error_seen = st.sticky;
          res_cnt         = 2'd1;
          st_nxt.mode     = MODE_IDLE;
        end else if (text_byte == CH_NUL) begin
          st_nxt.sticky   = 1'b1;
          res0            = zero_res;
          res0.kind       = KIND_ERROR;
          res0.error_code = ERR_UNTERMINATED;
          res0.error_seen = 1'b1;
          res_cnt         = 2'd1;
          idle_go         = 1'b1;
        end else begin
          res0            = zero_res;
          res0.kind       = KIND_STRCHAR;
          res0.char_value = text_byte;
          res0.error_seen = st.sticky;
          res_cnt         = 2'd1;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (is_digit) begin
          if (st.mode == MODE_INT) begin
            // saturate at all ones once the value would overflow
            if (|int_wide[INT_BITS+3:INT_BITS]) begin
              st_nxt.int_acc = '1;
            end else begin
              st_nxt.int_acc = int_wide[INT_BITS-1:0];
            end
          end else if (st.frac_cnt < FRAC_DIGITS_MAX) begin
            st_nxt.frac_acc = frac_wide[FRAC_BITS-1:0];
            st_nxt.frac_cnt = st.frac_cnt + 4'd1;
          end
        end else if ((text_byte == CH_DOT) && (st.mode == MODE_INT)) begin
          st_nxt.mode = MODE_FRAC;
        end else begin
          res0             = zero_res;
          res0.kind        = KIND_NUMBER;
          res0.is_negative = st.sign;
          res0.int_part    = st.int_acc;
          res0.frac_part   = st.frac_acc;
          res0.frac_count  = st.frac_cnt;
          res0.error_seen  = st.sticky;
          res_cnt          = 2'd1;
          st_nxt.sign      = 1'b0;
          st_nxt.int_acc   = '0;
          st_nxt.frac_acc  = '0;
          st_nxt.frac_cnt  = '0;
          idle_go          = 1'b1;
        end
      end
      default: begin
        idle_go = 1'b1;
      end
    endcase

    // idle-mode handling of the byte, also reached after a number ends or on a NUL inside a string
    if (idle_go) begin
      st_nxt.mode = MODE_IDLE;
      idle_res    = zero_res;
      priority if (text_byte == CH_NUL) begin
        idle_emit           = 1'b1;
        idle_res.kind       = KIND_END;
        idle_res.error_seen = st_nxt.sticky;
        st_nxt.sticky       = 1'b0;
      end else if (text_byte == CH_LBRACE) begin
        idle_emit     = 1'b1;
        idle_res.kind = KIND_LBRACE;
      end else if (text_byte == CH_RBRACE) begin
        idle_emit     = 1'b1;
        idle_res.kind = KIND_RBRACE;
      end else if (text_byte == CH_LBRACKET) begin
        idle_emit     = 1'b1;
        idle_res.kind = KIND_LBRACKET;
      end else if (text_byte == CH_RBRACKET) begin
        idle_emit     = 1'b1;
        idle_res.kind = KIND_RBRACKET;
      end else if (text_byte == CH_COLON) begin
        idle_emit     = 1'b1;
        idle_res.kind = KIND_COLON;
      end else if (text_byte == CH_QUOTE) begin
        st_nxt.mode = MODE_STR;
      end else if (text_byte == CH_MINUS) begin
        st_nxt.sign     = 1'b1;
        st_nxt.int_acc  = '0;
        st_nxt.frac_acc = '0;
        st_nxt.frac_cnt = '0;
        st_nxt.mode     = MODE_INT;
      end else if (is_digit) begin
        st_nxt.sign     = 1'b0;
        st_nxt.int_acc  = {{(INT_BITS-4){1'b0}}, digit};
        st_nxt.frac_acc = '0;
        st_nxt.frac_cnt = '0;
        st_nxt.mode     = MODE_INT;
      end else if (is_space) begin
        idle_emit = 1'b0;
      end else begin
        st_nxt.sticky       = 1'b1;
        idle_emit           = 1'b1;
        idle_res.kind       = KIND_ERROR;
        idle_res.error_code = ERR_UNEXPECTED;
      end
      if (idle_emit && (idle_res.kind != KIND_END)) begin
        idle_res.error_seen = st_nxt.sticky;
      end
      if (idle_emit) begin
        if (res_cnt == 2'd0) begin
          res0 = idle_res;
        end else begin
          res1 = idle_res;
        end
        res_cnt = res_cnt + 2'd1;
      end
    end

    if (res_cnt == 2'd1) begin
      res0.last_of_run = 1'b1;
    end
    if (res_cnt == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
  end

endmodule

>>> hw/rtl/jbt_obuf.sv
// Two-entry result buffer: takes up to two results per cycle, sends one per transfer.
module jbt_obuf
  import jbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  rslt_t      push0,
  input  rslt_t      push1,
  output logic [1:0] fill,
  output logic       out_valid,
  input  logic       out_ready,
  output rslt_t      head
);

  rslt_t      slot_r [2];
  rslt_t      slot_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_pop;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign cnt_pop   = cnt_r - {1'b0, pop};
  assign head      = slot_r[0];
  assign fill      = cnt_r;

  always_comb begin
    // shift out the sent entry, then append behind what stays
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = slot_r[1];
    if (cnt_pop == 2'd0) begin
      if (push_cnt != 2'd0) begin
        slot_nxt[0] = push0;
      end
      if (push_cnt == 2'd2) begin
        slot_nxt[1] = push1;
      end
    end else if (cnt_pop == 2'd1) begin
      if (push_cnt != 2'd0) begin
        slot_nxt[1] = push0;
      end
    end
    cnt_nxt = cnt_pop + push_cnt;
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/json_byte_tokenizer_top.sv
// Top level of the JSON byte tokenizer: input register, scanner state and result buffer.
//
//   channel | dir | tdata                          | tuser      | tlast
//   in_     | in  | text_byte[7:0]                 | -          | -
//   out_    | out | result fields, see port below  | token_kind | last_of_run
//
// One text byte is taken per cycle while each byte yields at most one result and
// out_tready stays high. A byte that ends a number and is itself a token, or a
// NUL inside a string, yields two results; the room check ignores the transfer
// leaving the buffer in the same cycle, so in a steady stream that byte and the
// next result-giving byte are each held back while the buffer drains. The input
// register feeds the scan logic, whose results land in a two-entry output buffer;
// in_tready depends only on registered state. Reset (rst_n low, synchronous) empties
// both stages and returns the scanner to idle with the error flag clear.
module json_byte_tokenizer_top
  import jbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] char_value, [8] is_negative, [40:9] int_part, [70:41] frac_part,
  // [74:71] frac_count, [76:75] error_code, [77] error_seen, [79:78] zero
  output logic [79:0] out_tdata,
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast
);

  logic        in_v_r;
  logic [7:0]  byte_r;
  scan_state_t st_r;
  scan_state_t st_nxt;
  logic [1:0]  res_cnt;
  rslt_t       res0;
  rslt_t       res1;
  logic [1:0]  fill;
  logic        adv;
  logic [2:0]  room_sum;
  rslt_t       head;

  jbt_scan u_scan (
    .st        (st_r),
    .text_byte (byte_r),
    .st_nxt    (st_nxt),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  // advance only when the buffer has room without counting this cycle's transfer
  assign room_sum  = {1'b0, fill} + {1'b0, res_cnt};
  assign adv       = in_v_r && (room_sum <= 3'd2);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  jbt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (adv ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .fill      (fill),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {2'b00, head.error_seen, head.error_code, head.frac_count,
                      head.frac_part, head.int_part, head.is_negative, head.char_value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

endmodule
